// ===== design/bds_pkg.sv =====
package bds_pkg;

    localparam int CAN_ID_W   = 11;
    localparam int SEQ_W      = 7;
    localparam int BODY_W     = 56;
    localparam int FRAME_W    = 40;
    localparam int CFG_DATA_W = 11;

    // Input command codes
    localparam logic CMD_INIT  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_RESP  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    // Abort codes
    localparam logic ABORT_SEQ    = 1'b0;
    localparam logic ABORT_REFUSE = 1'b1;

    // Configuration register indexes
    localparam logic REG_REPLY_CAN_ID   = 1'b0;
    localparam logic REG_BLOCK_SEGMENTS = 1'b1;

    // SDO command specifiers
    localparam logic [7:0] SCS_BLK_INIT = 8'hA0;
    localparam logic [7:0] SCS_BLK_END  = 8'hA1;
    localparam logic [7:0] SCS_BLK_ACK  = 8'hA2;
    localparam logic [2:0] CCS_BLK_END  = 3'b110;

    localparam logic [SEQ_W-1:0]  SEQ_FIRST  = 7'd1;
    localparam logic [SEQ_W-1:0]  SEQ_SECOND = 7'd2;
    localparam logic [2:0]        FULL_LEN   = 3'd7;
    localparam logic [BODY_W-1:0] BODY_MASK  = {BODY_W{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_SUB,
        PH_END
    } t_phase;

    typedef struct packed {
        logic              cmd;
        logic [15:0]       object_index;
        logic [7:0]        object_subindex;
        logic [7:0]        frame_head;
        logic [BODY_W-1:0] frame_body;
        logic              sink_refuses;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CAN_ID_W-1:0] tx_id;
        logic [FRAME_W-1:0]  frame_bytes;
        logic [BODY_W-1:0]   seg_data;
        logic [2:0]          seg_length;
        logic                abort_code;
        logic                transfer_done;
        logic                last;
    } t_out_beat;

    // One accepted item's results: one or two beats
    typedef struct packed {
        logic      two;
        t_out_beat res0;
        t_out_beat res1;
    } t_q_entry;

    function automatic t_out_beat mk_beat(
        input logic [1:0]          kind,
        input logic [CAN_ID_W-1:0] can_id,
        input logic [FRAME_W-1:0]  frame,
        input logic [BODY_W-1:0]   data,
        input logic [2:0]          len,
        input logic                code,
        input logic                done
    );
        t_out_beat b;
        b.kind          = kind;
        b.tx_id         = (kind == KIND_DATA) ? '0 : can_id;
        b.frame_bytes   = frame;
        b.seg_data      = data;
        b.seg_length    = len;
        b.abort_code    = code;
        b.transfer_done = done;
        b.last          = 1'b0;
        return b;
    endfunction

endpackage

// ===== design/block_download_server_top.sv =====
// Server side of a CANopen SDO block download. An initiate beat answers with the
// block-initiate response (0xA0, index, subindex, block size) and arms sequence 1;
// each client frame beat is checked against the expected sequence number, the
// segment it carries is held back one frame and written out when the next frame
// arrives, sub-blocks are acknowledged with 0xA2 at the block size or on the
// last-segment flag, and the end frame writes the final 7-n bytes and answers 0xA1
// with transfer_done. Each input beat yields zero, one or two result beats, the
// last of them marked by last. The front classifies a beat and updates the transfer
// state in the cycle it is accepted, so one input beat is taken every clock while the
// queue has room; its results go through a QUEUE_DEPTH-entry queue to the back, which
// delivers one result beat per clock from a registered output while the receiver is
// ready. Sustained throughput is therefore one input beat per cycle while beats yield
// at most one result and the receiver is ready; the queue absorbs bursts. A result is
// registered in the queue and then in the output register before it shows at o_out.
// Write the configuration registers (0: reply CAN id, 1: block size) only while the
// block is idle; the port is always ready. No initialization pass is needed after reset.
module block_download_server_top import bds_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [CAN_ID_W-1:0] r_reply_can_id;
    logic [SEQ_W-1:0]    r_block_segments;

    // Front to queue
    logic     w_push;
    t_q_entry w_push_entry;
    logic     w_not_full;

    // Queue to back
    logic     w_pop_valid;
    logic     w_pop_ready;
    t_q_entry w_pop_entry;

    assign o_cfg_ready = 1'b1;

    // Take a configuration beat on every valid cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_can_id   <= '0;
            r_block_segments <= 7'd127;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REPLY_CAN_ID:   r_reply_can_id   <= i_cfg_data[CAN_ID_W-1:0];
                REG_BLOCK_SEGMENTS: r_block_segments <= i_cfg_data[SEQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept, classify against the transfer state, form the result beats
    bds_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in             (i_in),
        .i_reply_can_id   (r_reply_can_id),
        .i_block_segments (r_block_segments),
        .i_q_ready        (w_not_full),
        .o_q_valid        (w_push),
        .o_q_entry        (w_push_entry)
    );

    // Queue: decouple the front from output back-pressure
    bds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_push_entry),
        .o_not_full   (w_not_full),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_entry  (w_pop_entry)
    );

    // Back: serialize one or two result beats per entry onto the output register
    bds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_pop_valid),
        .o_q_ready   (w_pop_ready),
        .i_q_entry   (w_pop_entry),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // The second result of an item follows its first without a gap
    a_pair_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last) |=> o_out_valid)
        else $error("second result beat of an item did not follow directly");

    // A data write never carries a CAN id or frame bytes
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind == KIND_DATA) |->
            (o_out.tx_id == '0 && o_out.frame_bytes == '0 && !o_out.transfer_done))
        else $error("data write beat carries response fields");

    // Completion only on the final end response, which closes its item
    a_done_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.transfer_done) |->
            (o_out.kind == KIND_RESP && o_out.frame_bytes == {32'd0, SCS_BLK_END}
             && o_out.last))
        else $error("transfer_done on a beat other than the end response");

    // Front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_not_full)
        else $error("result entry pushed into a full queue");

    // Nothing is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// ===== design/bds_front.sv =====
module bds_front import bds_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in,
    input  logic [CAN_ID_W-1:0]   i_reply_can_id,
    input  logic [SEQ_W-1:0]      i_block_segments,
    input  logic                  i_q_ready,
    output logic                  o_q_valid,
    output t_q_entry              o_q_entry
);

    t_phase              r_phase, n_phase;
    logic [SEQ_W-1:0]    r_expected_seq, n_expected_seq;
    logic [BODY_W-1:0]   r_held, n_held;
    logic                r_aborted, n_aborted;

    logic                w_accept;
    logic [SEQ_W-1:0]    w_seq;
    logic                w_flag;
    logic [2:0]          w_end_n;
    logic [2:0]          w_end_len;
    logic [BODY_W-1:0]   w_end_mask;
    logic [FRAME_W-1:0]  w_init_frame;
    logic [FRAME_W-1:0]  w_ack_frame;
    logic [1:0]          w_cnt;
    t_out_beat           w_res0, w_res1;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && i_q_ready;
    assign w_seq      = i_in.frame_head[SEQ_W-1:0];
    assign w_flag     = i_in.frame_head[7];
    assign w_end_n    = i_in.frame_head[4:2];
    assign w_end_len  = FULL_LEN - w_end_n;
    assign w_end_mask = BODY_MASK >> {w_end_n, 3'b000};

    assign w_init_frame = {1'b0, i_block_segments, i_in.object_subindex,
                           i_in.object_index[15:8], i_in.object_index[7:0], SCS_BLK_INIT};
    assign w_ack_frame  = {16'd0, 1'b0, i_block_segments, 1'b0, w_seq, SCS_BLK_ACK};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_expected_seq <= SEQ_FIRST;
            r_held         <= '0;
            r_aborted      <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_expected_seq <= n_expected_seq;
            r_held         <= n_held;
            r_aborted      <= n_aborted;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_expected_seq = r_expected_seq;
        n_held         = r_held;
        n_aborted      = r_aborted;
        w_res0         = '0;
        w_res1         = '0;
        w_cnt          = 2'd0;

        if (i_in.cmd == CMD_INIT) begin
            w_res0         = mk_beat(KIND_RESP, i_reply_can_id, w_init_frame, '0, '0,
                                     1'b0, 1'b0);
            w_cnt          = 2'd1;
            n_expected_seq = SEQ_FIRST;
            n_phase        = PH_START;
            n_aborted      = 1'b0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_START: begin
                    if (w_seq != r_expected_seq) begin
                        w_res0    = mk_beat(KIND_ABORT, i_reply_can_id, '0, '0, '0,
                                            ABORT_SEQ, 1'b0);
                        w_cnt     = 2'd1;
                        n_aborted = 1'b1;
                        n_phase   = PH_END;
                    end else begin
                        n_held         = i_in.frame_body;
                        n_expected_seq = SEQ_SECOND;
                        n_phase        = PH_SUB;
                    end
                end
                PH_SUB: begin
                    if (i_in.sink_refuses) begin
                        w_res0    = mk_beat(KIND_ABORT, i_reply_can_id, '0, '0, '0,
                                            ABORT_REFUSE, 1'b0);
                        w_cnt     = 2'd1;
                        n_aborted = 1'b1;
                        n_phase   = PH_END;
                    end else begin
                        // Release the segment held back from the previous frame
                        w_res0 = mk_beat(KIND_DATA, i_reply_can_id, '0, r_held, FULL_LEN,
                                         1'b0, 1'b0);
                        w_cnt  = 2'd1;
                        if (w_seq != r_expected_seq) begin
                            w_res1    = mk_beat(KIND_ABORT, i_reply_can_id, '0, '0, '0,
                                                ABORT_SEQ, 1'b0);
                            w_cnt     = 2'd2;
                            n_aborted = 1'b1;
                            n_phase   = PH_END;
                        end else begin
                            n_held         = i_in.frame_body;
                            n_expected_seq = w_seq + SEQ_FIRST;
                            if (w_flag) begin
                                n_phase = PH_END;
                            end
                            if (w_seq == i_block_segments || w_flag) begin
                                w_res1         = mk_beat(KIND_RESP, i_reply_can_id,
                                                         w_ack_frame, '0, '0, 1'b0, 1'b0);
                                w_cnt          = 2'd2;
                                n_expected_seq = SEQ_FIRST;
                            end
                        end
                    end
                end
                PH_END: begin
                    if (i_in.frame_head[7:5] == CCS_BLK_END) begin
                        if (!r_aborted) begin
                            if (i_in.sink_refuses) begin
                                w_res0    = mk_beat(KIND_ABORT, i_reply_can_id, '0, '0,
                                                    '0, ABORT_REFUSE, 1'b0);
                                n_aborted = 1'b1;
                            end else begin
                                w_res0 = mk_beat(KIND_DATA, i_reply_can_id, '0,
                                                 r_held & w_end_mask, w_end_len,
                                                 1'b0, 1'b0);
                            end
                            w_res1 = mk_beat(KIND_RESP, i_reply_can_id,
                                             {32'd0, SCS_BLK_END}, '0, '0, 1'b0, 1'b1);
                            w_cnt  = 2'd2;
                        end else begin
                            w_res0 = mk_beat(KIND_RESP, i_reply_can_id,
                                             {32'd0, SCS_BLK_END}, '0, '0, 1'b0, 1'b1);
                            w_cnt  = 2'd1;
                        end
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_cnt == 2'd2) begin
            w_res1.last = 1'b1;
        end else begin
            w_res0.last = 1'b1;
        end

        // Hold all state unless the item is actually taken
        if (!w_accept) begin
            n_phase        = r_phase;
            n_expected_seq = r_expected_seq;
            n_held         = r_held;
            n_aborted      = r_aborted;
        end
    end

    assign o_q_valid      = w_accept && (w_cnt != 2'd0);
    assign o_q_entry.two  = (w_cnt == 2'd2);
    assign o_q_entry.res0 = w_res0;
    assign o_q_entry.res1 = w_res1;

endmodule

// ===== design/bds_queue.sv =====
module bds_queue import bds_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_push_entry,
    output logic     o_not_full,
    output logic     o_pop_valid,
    input  logic     i_pop_ready,
    output t_q_entry o_pop_entry
);

    localparam int AW = $clog2(DEPTH);

    t_q_entry        r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [AW:0]     r_count;
    logic            w_pop;
    logic            w_push;

    assign o_not_full  = (r_count != (AW+1)'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_entry = r_mem[r_rd_ptr];
    assign w_pop       = o_pop_valid && i_pop_ready;
    assign w_push      = i_push && o_not_full;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    // Wrap the pointers at the last entry so any depth works
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/bds_back.sv =====
module bds_back import bds_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_ready,
    input  t_q_entry  i_q_entry,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    logic      r_out_valid, n_out_valid;
    logic      r_pend_valid, n_pend_valid;
    t_out_beat r_out, n_out;
    t_out_beat r_pend, n_pend;
    logic      w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_q_ready   = w_slot_free && !r_pend_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_pend       = r_pend;
        if (w_slot_free) begin
            if (r_pend_valid) begin
                n_out        = r_pend;
                n_out_valid  = 1'b1;
                n_pend_valid = 1'b0;
            end else if (i_q_valid) begin
                n_out        = i_q_entry.res0;
                n_out_valid  = 1'b1;
                n_pend       = i_q_entry.res1;
                n_pend_valid = i_q_entry.two;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

endmodule

// ===== bench/block_download_server_top_test.sv =====
module block_download_server_top_test;
    import bds_pkg::*;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int MAX_REPORTS   = 30;
    localparam int PHASES        = 4;

    // One row of the directed script: the input beat and, where it can be read off
    // at a glance, the result beats it must produce.
    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        logic [1:0] n_typed;
        t_out_beat res_a;
        t_out_beat res_b;
    } t_row;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_beat              in_beat;
    logic                  out_valid;
    logic                  out_ready;
    t_out_beat             out_beat;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    block_download_server_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow of the transfer: registers and state as they stand after reset.
    logic [CAN_ID_W-1:0] reply_id      = '0;
    logic [SEQ_W-1:0]    seg_per_block = 7'd127;
    t_phase              xfer_phase    = PH_IDLE;
    logic [SEQ_W-1:0]    want_seq      = SEQ_FIRST;
    logic [BODY_W-1:0]   held_seg      = '0;
    logic                xfer_aborted  = 1'b0;

    t_out_beat pending[$];        // result beats still owed by the block, oldest first
    t_out_beat fresh[$];          // beats forecast for the beat just accepted
    t_out_beat typed_results[$];  // hand-written results of the current script row
    logic      use_typed     = 1'b0;

    int mismatches    = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic t_in_beat initiate(logic [15:0] idx, logic [7:0] sub);
        t_in_beat b;
        b                 = '0;
        b.cmd             = CMD_INIT;
        b.object_index    = idx;
        b.object_subindex = sub;
        return b;
    endfunction

    function automatic t_in_beat client(logic [7:0] head, logic [BODY_W-1:0] body,
                                        logic refuse);
        t_in_beat b;
        b              = '0;
        b.cmd          = CMD_FRAME;
        b.frame_head   = head;
        b.frame_body   = body;
        b.sink_refuses = refuse;
        return b;
    endfunction

    function automatic logic [BODY_W-1:0] rand_body();
        return BODY_W'({$urandom(), $urandom()});
    endfunction

    function automatic t_out_beat result_beat(logic [1:0] kind, logic [CAN_ID_W-1:0] id,
                                              logic [FRAME_W-1:0] frame,
                                              logic [BODY_W-1:0] data, logic [2:0] len,
                                              logic code, logic done, logic fin);
        t_out_beat r;
        r.kind          = kind;
        r.tx_id         = (kind == KIND_DATA) ? '0 : id;
        r.frame_bytes   = frame;
        r.seg_data      = data;
        r.seg_length    = len;
        r.abort_code    = code;
        r.transfer_done = done;
        r.last          = fin;
        return r;
    endfunction

    function automatic t_row row_of(t_in_beat b, logic typed, logic [1:0] n,
                                    t_out_beat a, t_out_beat c);
        t_row r;
        r.beat    = b;
        r.typed   = typed;
        r.n_typed = n;
        r.res_a   = a;
        r.res_b   = c;
        return r;
    endfunction

    // Work out the result beats of one accepted beat and advance the shadow state.
    function automatic void forecast(t_in_beat b);
        logic [SEQ_W-1:0]  seq;
        logic              flag;
        logic [2:0]        len;
        logic [BODY_W-1:0] mask;
        seq  = b.frame_head[SEQ_W-1:0];
        flag = b.frame_head[7];
        fresh.delete();
        if (b.cmd == CMD_INIT) begin
            // Initiate restarts the transfer from any phase
            fresh.push_back(result_beat(KIND_RESP, reply_id,
                {1'b0, seg_per_block, b.object_subindex, b.object_index[15:8],
                 b.object_index[7:0], SCS_BLK_INIT}, '0, '0, ABORT_SEQ, 1'b0, 1'b0));
            want_seq     = SEQ_FIRST;
            xfer_phase   = PH_START;
            xfer_aborted = 1'b0;
        end else begin
            case (xfer_phase)
                PH_START: begin
                    // First frame: hold the segment, nothing goes out yet unless the sequence is wrong
                    if (seq != want_seq) begin
                        fresh.push_back(result_beat(KIND_ABORT, reply_id, '0, '0, '0,
                                                    ABORT_SEQ, 1'b0, 1'b0));
                        xfer_aborted = 1'b1;
                        xfer_phase   = PH_END;
                    end else begin
                        held_seg   = b.frame_body;
                        want_seq   = SEQ_SECOND;
                        xfer_phase = PH_SUB;
                    end
                end
                PH_SUB: begin
                    if (b.sink_refuses) begin
                        fresh.push_back(result_beat(KIND_ABORT, reply_id, '0, '0, '0,
                                                    ABORT_REFUSE, 1'b0, 1'b0));
                        xfer_aborted = 1'b1;
                        xfer_phase   = PH_END;
                    end else begin
                        // The held segment goes out even when the sequence is wrong
                        fresh.push_back(result_beat(KIND_DATA, reply_id, '0, held_seg,
                                                    FULL_LEN, ABORT_SEQ, 1'b0, 1'b0));
                        if (seq != want_seq) begin
                            fresh.push_back(result_beat(KIND_ABORT, reply_id, '0, '0, '0,
                                                        ABORT_SEQ, 1'b0, 1'b0));
                            xfer_aborted = 1'b1;
                            xfer_phase   = PH_END;
                        end else begin
                            held_seg = b.frame_body;
                            want_seq = seq + 1'b1;
                            if (flag) xfer_phase = PH_END;
                            if (seq == seg_per_block || flag) begin
                                fresh.push_back(result_beat(KIND_RESP, reply_id,
                                    {16'h0, 1'b0, seg_per_block, 1'b0, seq, SCS_BLK_ACK},
                                    '0, '0, ABORT_SEQ, 1'b0, 1'b0));
                                want_seq = SEQ_FIRST;
                            end
                        end
                    end
                end
                PH_END: begin
                    // Only a client end frame counts here; drop anything else
                    if (b.frame_head[7:5] == CCS_BLK_END) begin
                        len = FULL_LEN - b.frame_head[4:2];
                        if (!xfer_aborted) begin
                            if (b.sink_refuses) begin
                                fresh.push_back(result_beat(KIND_ABORT, reply_id, '0, '0,
                                                            '0, ABORT_REFUSE, 1'b0, 1'b0));
                                xfer_aborted = 1'b1;
                            end else begin
                                mask = (len == 3'd0) ? '0
                                     : BODY_MASK >> (8 * (7 - int'(len)));
                                fresh.push_back(result_beat(KIND_DATA, reply_id, '0,
                                                            held_seg & mask, len,
                                                            ABORT_SEQ, 1'b0, 1'b0));
                            end
                        end
                        fresh.push_back(result_beat(KIND_RESP, reply_id,
                                                    {32'h0, SCS_BLK_END}, '0, '0,
                                                    ABORT_SEQ, 1'b1, 1'b0));
                        xfer_phase = PH_IDLE;
                    end
                end
                default: ;  // frames while idle are dropped
            endcase
        end
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Monitor: track register writes, forecast every accepted input beat and
    // check every accepted result beat against the oldest one owed.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_REPLY_CAN_ID) reply_id = cfg_data[CAN_ID_W-1:0];
                else seg_per_block = cfg_data[SEQ_W-1:0];
            end
            if (in_valid && in_ready) begin
                forecast(in_beat);
                // Script rows with typed results are checked against those instead
                if (use_typed) foreach (typed_results[k]) pending.push_back(typed_results[k]);
                else foreach (fresh[k]) pending.push_back(fresh[k]);
            end
            if (out_valid && out_ready) begin
                if (pending.size() == 0) begin
                    note_mismatch("result beat with nothing expected");
                end else begin
                    t_out_beat want;
                    want = pending.pop_front();
                    compare_field("kind", out_beat.kind, want.kind);
                    compare_field("tx_id", out_beat.tx_id, want.tx_id);
                    compare_field("frame_bytes", out_beat.frame_bytes, want.frame_bytes);
                    compare_field("seg_data", out_beat.seg_data, want.seg_data);
                    compare_field("seg_length", out_beat.seg_length, want.seg_length);
                    compare_field("abort_code", out_beat.abort_code, want.abort_code);
                    compare_field("transfer_done", out_beat.transfer_done,
                                  want.transfer_done);
                    compare_field("last", out_beat.last, want.last);
                end
            end
        end
    end

    // Receiver: stall at random, re-drawn every cycle.
    initial begin
        out_ready = 1'b1;
        forever begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one input beat; call at a falling edge, returns after the accepting edge.
    // Valid stays high afterwards so back-to-back beats need no extra assignment.
    task automatic offer(t_in_beat b);
        int gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        // Count only beats the block acts on
        if (b.cmd == CMD_INIT || !(xfer_phase == PH_IDLE ||
            (xfer_phase == PH_END && b.frame_head[7:5] != CCS_BLK_END)))
            items_sent++;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_beat  = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid, wait for every owed result, then let in-flight beats finish.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One transfer: initiate, a run of in-sequence data frames ending on the
    // last-segment flag, then the end frame. A few frames carry a bad sequence,
    // a store refusal or a restart; stray frames land in the end and idle phases.
    task automatic random_transfer();
        int         frames;
        int         pick;
        logic [7:0] head;
        logic       refuse;
        @(negedge clk);
        offer(initiate(16'($urandom()), 8'($urandom())));
        pick   = $urandom_range(9);
        frames = (pick < 6) ? $urandom_range(2, 8)
               : (pick < 9) ? $urandom_range(2, 24) : $urandom_range(2, 140);
        for (int k = 0; k < frames; k++) begin
            @(negedge clk);
            // Drop valid before leaving so the last beat is not taken twice
            if (xfer_phase == PH_END) begin
                in_valid = 1'b0;
                break;
            end
            head   = {(k == frames - 1) ? 1'b1 : 1'b0, want_seq};
            refuse = ($urandom_range(99) < 3);
            if ($urandom_range(99) < 3) head[6:0] ^= 7'($urandom_range(1, 127));
            if ($urandom_range(99) < 2) begin
                offer(initiate(16'($urandom()), 8'($urandom())));
                @(negedge clk);
                head[6:0] = want_seq;
            end
            offer(client(head, rand_body(), refuse));
        end
        @(negedge clk);
        if ($urandom_range(99) < 8) begin
            head = 8'($urandom_range(255));
            if (head[7:5] == CCS_BLK_END) head[5] = 1'b1;
            offer(client(head, rand_body(), 1'($urandom_range(1))));
            @(negedge clk);
        end
        head = {CCS_BLK_END, 3'($urandom_range(7)), 2'($urandom_range(3))};
        offer(client(head, rand_body(), ($urandom_range(99) < 5)));
        if ($urandom_range(99) < 8) begin
            @(negedge clk);
            offer(client(8'($urandom_range(255)), rand_body(), 1'($urandom_range(1))));
        end
    endtask

    initial begin
        t_row                  script[$];
        t_out_beat             none_b;
        t_out_beat             end_done;
        logic [CFG_DATA_W-1:0] cfg_ids[PHASES];
        logic [CFG_DATA_W-1:0] cfg_sizes[PHASES];
        int                    phase_send[PHASES];
        int                    phase_stall[PHASES];
        int                    target;
        int                    mid;
        logic                  paused;

        // Hold every input known from the start
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_beat   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_REPLY_CAN_ID;
        cfg_data  = '0;

        none_b   = '0;
        end_done = result_beat(KIND_RESP, '0, {32'h0, SCS_BLK_END}, '0, '0, ABORT_SEQ,
                               1'b1, 1'b1);

        // Directed script, run with the reset registers (id 0, 127 segments)
        // frame while idle: dropped
        script.push_back(row_of(client(8'hFF, BODY_MASK, 1'b1), 1'b1, 2'd0, none_b, none_b));
        // initiate with all-ones index and subindex
        script.push_back(row_of(initiate(16'hFFFF, 8'hFF), 1'b1, 2'd1,
            result_beat(KIND_RESP, '0, {8'h7F, 8'hFF, 16'hFFFF, SCS_BLK_INIT}, '0, '0,
                        ABORT_SEQ, 1'b0, 1'b1), none_b));
        // wrong sequence on the first frame: abort
        script.push_back(row_of(client(8'h05, '0, 1'b0), 1'b1, 2'd1,
            result_beat(KIND_ABORT, '0, '0, '0, '0, ABORT_SEQ, 1'b0, 1'b1), none_b));
        // not an end frame while waiting for one: dropped
        script.push_back(row_of(client(8'h1F, BODY_MASK, 1'b0), 1'b1, 2'd0, none_b, none_b));
        // end frame after an abort: only the end response
        script.push_back(row_of(client({CCS_BLK_END, 5'h0}, '0, 1'b0), 1'b1, 2'd1,
                                end_done, none_b));
        script.push_back(row_of(initiate(16'h0000, 8'h00), 1'b1, 2'd1,
            result_beat(KIND_RESP, '0, {8'h7F, 8'h00, 16'h0000, SCS_BLK_INIT}, '0, '0,
                        ABORT_SEQ, 1'b0, 1'b1), none_b));
        script.push_back(row_of(client(8'h01, BODY_MASK, 1'b0), 1'b1, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h02, '0, 1'b0), 1'b0, 2'd0, none_b, none_b));
        // store refusal inside a sub-block, then end frame with refusal after abort
        script.push_back(row_of(client(8'h03, BODY_MASK, 1'b1), 1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client({CCS_BLK_END, 3'd7, 2'b11}, BODY_MASK, 1'b1),
                                1'b0, 2'd0, none_b, none_b));
        // last-segment flag, then end frame with n = 7 (zero-length write)
        script.push_back(row_of(initiate(16'h1234, 8'h56), 1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h01, 56'h01_2345_6789_ABCD, 1'b0),
                                1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h82, 56'hFE_DCBA_9876_5432, 1'b0),
                                1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client({CCS_BLK_END, 3'd7, 2'b00}, '0, 1'b0),
                                1'b0, 2'd0, none_b, none_b));
        // end frame whose write the store refuses: abort, then end response
        script.push_back(row_of(initiate(16'hABCD, 8'hEF), 1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h01, 56'h11_2233_4455_6677, 1'b0),
                                1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h82, 56'h88_99AA_BBCC_DDEE, 1'b0),
                                1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client({CCS_BLK_END, 3'd1, 2'b01}, '0, 1'b1),
                                1'b0, 2'd0, none_b, none_b));
        // wrong sequence inside a sub-block: write the held segment, then abort
        script.push_back(row_of(initiate(16'h8000, 8'h80), 1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h01, 56'h80_0000_0000_0001, 1'b0),
                                1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h07, '0, 1'b0), 1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client({CCS_BLK_END, 3'd2, 2'b10}, '0, 1'b0),
                                1'b0, 2'd0, none_b, none_b));
        // initiate in mid-transfer restarts; refusal on the first frame is ignored
        script.push_back(row_of(initiate(16'h5A5A, 8'hA5), 1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h01, BODY_MASK, 1'b0), 1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(initiate(16'h00FF, 8'h0F), 1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h01, 56'hC0_FFEE_0000_BEEF, 1'b1),
                                1'b0, 2'd0, none_b, none_b));
        script.push_back(row_of(client(8'h82, BODY_MASK, 1'b0), 1'b0, 2'd0, none_b, none_b));
        // end frame with n = 0: full seven-byte write
        script.push_back(row_of(client({CCS_BLK_END, 3'd0, 2'b00}, '0, 1'b0),
                                1'b0, 2'd0, none_b, none_b));

        // Random phases: register settings and idling per phase
        cfg_ids     = '{11'h7FF, 11'h000, CFG_DATA_W'($urandom_range(2047)),
                        CFG_DATA_W'($urandom_range(2047))};
        cfg_sizes   = '{11'd1, 11'd127, 11'd3, CFG_DATA_W'($urandom_range(2, 12))};
        phase_send  = '{0, 80, 0, 25};
        phase_stall = '{0, 0, 80, 25};

        // Reset once, synchronous
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed script with no idling on either side
        for (int r = 0; r < script.size(); r++) begin
            @(negedge clk);
            use_typed = script[r].typed;
            typed_results.delete();
            if (script[r].n_typed >= 2'd1) typed_results.push_back(script[r].res_a);
            if (script[r].n_typed >= 2'd2) typed_results.push_back(script[r].res_b);
            offer(script[r].beat);
        end
        settle();
        use_typed = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            // Block is idle here: write both registers
            send_idle_pct = 0;
            stall_pct     = 0;
            write_reg(REG_REPLY_CAN_ID, cfg_ids[p]);
            write_reg(REG_BLOCK_SEGMENTS, cfg_sizes[p]);
            send_idle_pct = phase_send[p];
            stall_pct     = phase_stall[p];
            target = items_sent + RANDOM_ITEMS / PHASES;
            mid    = items_sent + RANDOM_ITEMS / (2 * PHASES);
            paused = 1'b0;
            while (items_sent < target) begin
                random_transfer();
                // Halfway through, pause the sender until the block has caught up
                if (!paused && items_sent >= mid) begin
                    settle();
                    paused = 1'b1;
                end
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
